// File: src/lftl_pkg.sv
package lftl_pkg;

  localparam int SLOTS_DEF = 24;

  localparam int MODE_W = 2;
  localparam int ID_W   = 29;
  localparam int LEN_W  = 4;
  localparam int DATA_W = 64;
  localparam int TIME_W = 48;
  localparam int IDX_W  = 5;
  localparam int HITS_W = 32;
  localparam int OUTC_W = 2;
  localparam int USED_W = 5;

  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 144;

  localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

  localparam logic [MODE_W-1:0] MODE_NOTE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [OUTC_W-1:0] OUTC_NONE     = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_UPDATED  = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_INSERTED = 2'd2;
  localparam logic [OUTC_W-1:0] OUTC_REPLACED = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]   ident;
    logic              ext;
    logic [HITS_W-1:0] hits;
    logic [TIME_W-1:0] tstamp;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] bytes;
  } entry_t;

  // Result of the shared compare unit on the entry just read.
  typedef struct packed {
    logic match;
    logic older;
  } cmp_t;

endpackage

// File: src/lftl_table.sv
module lftl_table #(
  parameter int SLOTS = lftl_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rd_en,
  input  logic [$clog2(SLOTS)-1:0]        rd_addr,
  input  logic                            wr_en,
  input  logic [$clog2(SLOTS)-1:0]        wr_addr,
  input  lftl_pkg::entry_t                wr_data,
  input  logic [lftl_pkg::ID_W-1:0]       key_id,
  input  logic                            key_ext,
  input  logic [lftl_pkg::TIME_W-1:0]     min_time,
  output lftl_pkg::entry_t                rd_data,
  output lftl_pkg::cmp_t                  cmp
);
  import lftl_pkg::*;

  entry_t mem [SLOTS];
  entry_t rd_data_r;

  // Entries beyond the fill count are never read, so the store needs no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

  always_comb begin
    cmp.match = (rd_data_r.ident == key_id) && (rd_data_r.ext == key_ext);
    cmp.older = rd_data_r.tstamp < min_time;
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en))
    else $error("table read and write issued in the same cycle");

endmodule

// File: src/live_frame_table_lru.sv
// Table of recently seen CAN frames, one entry per identifier and format, with
// oldest-timestamp replacement once all SLOTS entries are used. Items are handled
// one at a time by a small sequencer around a single-port table memory that
// delivers one entry per cycle to a shared compare unit. A noted frame is read
// entry by entry until a match (the scan stops early at a match) or until all
// entries_used entries are read, then it is written and its result loaded; a read
// fetches one entry, and a clear or an ignored item goes straight to the output
// stage; a result held back by out_tready waits there until it is taken.
// in_tready is high again as soon as the result is in the output register.
// Clearing only resets the fill count, so there is no clearing pass after reset.
module live_frame_table_lru #(
  parameter int SLOTS = lftl_pkg::SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [0:0]                           cfg_data,    // live_enable
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // frame_id[28:0], extended[29], length_code[33:30], payload[97:34],
  // now_us[145:98], read_index[150:146], zero fill above
  input  logic [lftl_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic [lftl_pkg::MODE_W-1:0]          in_tuser,    // mode
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // note_outcome[1:0], entry_id[30:2], entry_extended[31], entry_count[63:32],
  // entry_length[67:64], entry_data[131:68], entries_used[136:132], zero fill above
  output logic [lftl_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tuser    // read_valid
);
  import lftl_pkg::*;

  localparam int IW   = $clog2(SLOTS);
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  // Input fields
  logic [ID_W-1:0]   f_id;
  logic              f_ext;
  logic [LEN_W-1:0]  f_len;
  logic [DATA_W-1:0] f_data;
  logic [TIME_W-1:0] f_now;
  logic [IDX_W-1:0]  f_idx;

  assign f_id   = in_tdata[28:0];
  assign f_ext  = in_tdata[29];
  assign f_len  = in_tdata[33:30];
  assign f_data = in_tdata[97:34];
  assign f_now  = in_tdata[145:98];
  assign f_idx  = in_tdata[150:146];

  // Control state
  logic [2:0]        state_r, state_nxt;
  logic              enable_r, enable_nxt;
  logic [CW-1:0]     used_r, used_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers
  logic [IW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              hit_r, hit_nxt;
  logic [IW-1:0]     tgt_idx_r, tgt_idx_nxt;
  logic [HITS_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [TIME_W-1:0] min_time_r, min_time_nxt;
  logic [IW-1:0]     min_idx_r, min_idx_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic              ext_r, ext_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [DATA_W-1:0] data_r, data_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [OUTC_W-1:0] res_outc_r, res_outc_nxt;
  logic              res_rvalid_r, res_rvalid_nxt;
  entry_t            res_entry_r, res_entry_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_user_r, out_user_nxt;

  // Table port
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;
  entry_t            rd_data;
  cmp_t              cmp;

  logic              in_fire;
  logic              issue;
  logic              full;
  logic              idx_ok;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign issue  = (state_r == S_SCAN) && (cnt_r < used_r);
  assign full   = (used_r == CW'(SLOTS));
  assign idx_ok = CMPW'(f_idx) < CMPW'(used_r);

  lftl_table #(
    .SLOTS(SLOTS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .key_id   (id_r),
    .key_ext  (ext_r),
    .min_time (min_time_r),
    .rd_data  (rd_data),
    .cmp      (cmp)
  );

  always_comb begin
    state_nxt      = state_r;
    enable_nxt     = enable_r;
    used_nxt       = used_r;
    cnt_nxt        = cnt_r;
    cmp_v_nxt      = issue;
    out_valid_nxt  = out_valid_r;
    cmp_idx_nxt    = IW'(cnt_r);
    hit_nxt        = hit_r;
    tgt_idx_nxt    = tgt_idx_r;
    hit_cnt_nxt    = hit_cnt_r;
    min_time_nxt   = min_time_r;
    min_idx_nxt    = min_idx_r;
    id_nxt         = id_r;
    ext_nxt        = ext_r;
    len_nxt        = len_r;
    data_nxt       = data_r;
    now_nxt        = now_r;
    res_outc_nxt   = res_outc_r;
    res_rvalid_nxt = res_rvalid_r;
    res_entry_nxt  = res_entry_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    rd_en          = 1'b0;
    rd_addr        = IW'(cnt_r);
    wr_en          = 1'b0;
    wr_addr        = tgt_idx_r;
    wr_data        = '0;

    if (cfg_valid) begin
      enable_nxt = cfg_data[0];
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          id_nxt         = f_id;
          ext_nxt        = f_ext;
          len_nxt        = (f_len > MAX_LEN) ? MAX_LEN : f_len;
          data_nxt       = f_data;
          now_nxt        = f_now;
          res_outc_nxt   = OUTC_NONE;
          res_rvalid_nxt = 1'b0;
          res_entry_nxt  = '0;
          hit_nxt        = 1'b0;
          cnt_nxt        = '0;
          state_nxt      = S_OUT;
          case (in_tuser)
            MODE_NOTE: begin
              if (enable_r) begin
                state_nxt = S_SCAN;
              end
            end
            MODE_READ: begin
              if (idx_ok) begin
                rd_en     = 1'b1;
                rd_addr   = IW'(f_idx);
                state_nxt = S_RD;
              end
            end
            MODE_CLEAR: begin
              used_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // One entry is read per cycle; its compare result arrives in the next cycle.
        rd_en = issue;
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (cmp_v_r && cmp.match) begin
          hit_nxt     = 1'b1;
          tgt_idx_nxt = cmp_idx_r;
          hit_cnt_nxt = rd_data.hits;
          state_nxt   = S_WRITE;
        end else begin
          // Strict comparison keeps the lowest index among equal timestamps.
          if (cmp_v_r && ((cmp_idx_r == '0) || cmp.older)) begin
            min_time_nxt = rd_data.tstamp;
            min_idx_nxt  = cmp_idx_r;
          end
          if (!issue && !cmp_v_r) begin
            state_nxt = S_WRITE;
          end
        end
      end

      S_RD: begin
        res_rvalid_nxt = 1'b1;
        res_entry_nxt  = rd_data;
        state_nxt      = S_OUT;
      end

      S_WRITE: begin
        wr_en          = 1'b1;
        wr_data.ident  = id_r;
        wr_data.ext    = ext_r;
        wr_data.hits   = hit_r ? (hit_cnt_r + 1'b1) : HITS_W'(1);
        wr_data.tstamp = now_r;
        wr_data.len    = len_r;
        wr_data.bytes  = data_r;
        if (hit_r) begin
          wr_addr      = tgt_idx_r;
          res_outc_nxt = OUTC_UPDATED;
        end else if (!full) begin
          wr_addr      = IW'(used_r);
          used_nxt     = used_r + 1'b1;
          res_outc_nxt = OUTC_INSERTED;
        end else begin
          wr_addr      = min_idx_r;
          res_outc_nxt = OUTC_REPLACED;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = res_rvalid_r;
          out_data_nxt  = {7'd0, USED_W'(used_r), res_entry_r.bytes, res_entry_r.len,
                           res_entry_r.hits, res_entry_r.ext, res_entry_r.ident,
                           res_outc_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b0;
      used_r      <= '0;
      cnt_r       <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      used_r      <= used_nxt;
      cnt_r       <= cnt_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    hit_r        <= hit_nxt;
    tgt_idx_r    <= tgt_idx_nxt;
    hit_cnt_r    <= hit_cnt_nxt;
    min_time_r   <= min_time_nxt;
    min_idx_r    <= min_idx_nxt;
    id_r         <= id_nxt;
    ext_r        <= ext_nxt;
    len_r        <= len_nxt;
    data_r       <= data_nxt;
    now_r        <= now_nxt;
    res_outc_r   <= res_outc_nxt;
    res_rvalid_r <= res_rvalid_nxt;
    res_entry_r  <= res_entry_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(SLOTS))
    else $error("fill count exceeds the table size");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE && !hit_r && !full) |=> (used_r == $past(used_r) + 1'b1))
    else $error("insertion did not advance the fill count");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!out_valid_r || out_tready)) |=> (out_valid_r && in_tready))
    else $error("result not loaded into the output register");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (cnt_r < CW'(SLOTS)))
    else $error("scan address beyond the table");

endmodule
